// ===== sv/dofe_pkg.sv =====
// ----------------------------------------------------------------------------
// dofe_pkg
// Shared types and constants for the DHCP option field extractor.
// ----------------------------------------------------------------------------
package dofe_pkg;

  // Option codes
  localparam logic [7:0] OPT_PAD        = 8'd0;
  localparam logic [7:0] OPT_END        = 8'd255;
  localparam logic [7:0] OPT_HOSTNAME   = 8'd12;
  localparam logic [7:0] OPT_REQ_ADDR   = 8'd50;
  localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
  localparam logic [7:0] OPT_PARAM_LIST = 8'd55;
  localparam logic [7:0] OPT_VENDOR     = 8'd60;
  localparam logic [7:0] OPT_AGENT      = 8'd82;

  // Option 82 sub-option codes
  localparam logic [7:0] SUB_CIRCUIT    = 8'd1;
  localparam logic [7:0] SUB_REMOTE     = 8'd2;
  localparam logic [7:0] CIRCUIT_LEN    = 8'd4;

  // Message types that get flagged
  localparam logic [7:0] MSG_DISCOVER   = 8'd1;
  localparam logic [7:0] MSG_REQUEST    = 8'd3;
  localparam logic [7:0] MSG_INFORM     = 8'd8;

  // Result kinds
  localparam logic [2:0] KIND_CODE      = 3'd0;
  localparam logic [2:0] KIND_PARAM     = 3'd1;
  localparam logic [2:0] KIND_VENDOR    = 3'd2;
  localparam logic [2:0] KIND_HOSTNAME  = 3'd3;
  localparam logic [2:0] KIND_REMOTE    = 3'd4;
  localparam logic [2:0] KIND_SUMMARY   = 3'd5;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SP_CODE,
    SP_LEN,
    SP_VALUE
  } sub_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [7:0]  message_type;
    logic [31:0] requested_address;
    logic [15:0] circuit_vlan;
    logic [7:0]  circuit_unit;
    logic [7:0]  circuit_port;
    logic [7:0]  option_total;
    logic        reportable;
    logic        end_of_run;
  } out_item_t;

endpackage

// ===== sv/dhcp_option_field_extractor.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_field_extractor
// Byte-wide DHCP options parser: reports option codes, passes through
// selected value bytes and sums up each packet on its last byte.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Payload              | Dir
//  --------+--------------------------------+----------------------+----
//  input   | in_valid, in_stall, in_data    | dofe_pkg::in_item_t  | in
//  result  | out_valid, out_stall, out_data | dofe_pkg::out_item_t | out
//
//  One request is taken per cycle while in_stall is low. The parse is combinational
//  from the parser registers into a 4-entry result queue; a byte yields 0, 1 or
//  2 results, and the result port drains one per cycle while out_stall is low.
//  in_stall rises only when the queue has fewer than two free slots, so a
//  burst of two-result bytes under a steady output stall backs up the input.
//  Reset (rst_n low, synchronous) empties the queue and clears the parser.
//  Results leave in order; out_data holds while out_stall is high.
// ----------------------------------------------------------------------------
module dhcp_option_field_extractor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dofe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dofe_pkg::out_item_t out_data
);

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  dofe_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           cur_code_r, cur_code_nxt;
  logic [7:0]           bytes_left_r, bytes_left_nxt;
  logic [2:0]           val_pos_r, val_pos_nxt;     // saturates, only 0..3 matter
  dofe_pkg::sub_phase_t sub_phase_r, sub_phase_nxt;
  logic [7:0]           sub_code_r, sub_code_nxt;
  logic [7:0]           sub_left_r, sub_left_nxt;
  logic [2:0]           sub_pos_r, sub_pos_nxt;     // saturates, only 0..5 matter
  logic [7:0]           type_r, type_nxt;
  logic [31:0]          addr_r, addr_nxt;
  logic [15:0]          vlan_r, vlan_nxt;
  logic [7:0]           unit_r, unit_nxt;
  logic [7:0]           port_r, port_nxt;
  logic                 circ_ok_r, circ_ok_nxt;
  logic [7:0]           codes_r, codes_nxt;

  // Per-byte results
  logic                 res_vld;
  logic [2:0]           res_kind;
  logic [7:0]           res_value;
  dofe_pkg::out_item_t  data_item, sum_item, wr0, wr1;
  logic [1:0]           wr_cnt;

  logic                 in_acc;
  logic [7:0]           b;

  assign in_acc = in_valid && !in_stall;
  assign b      = in_data.data_byte;

  // --------------------------------------------------------------------------
  // Single-pass parse of one byte
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt      = phase_r;
    cur_code_nxt   = cur_code_r;
    bytes_left_nxt = bytes_left_r;
    val_pos_nxt    = val_pos_r;
    sub_phase_nxt  = sub_phase_r;
    sub_code_nxt   = sub_code_r;
    sub_left_nxt   = sub_left_r;
    sub_pos_nxt    = sub_pos_r;
    type_nxt       = type_r;
    addr_nxt       = addr_r;
    vlan_nxt       = vlan_r;
    unit_nxt       = unit_r;
    port_nxt       = port_r;
    circ_ok_nxt    = circ_ok_r;
    codes_nxt      = codes_r;
    res_vld        = 1'b0;
    res_kind       = dofe_pkg::KIND_CODE;
    res_value      = b;

    case (phase_r)
      dofe_pkg::PH_CODE: begin
        if (b == dofe_pkg::OPT_END) begin
          phase_nxt = dofe_pkg::PH_DONE;
        end else if (b != dofe_pkg::OPT_PAD) begin
          cur_code_nxt = b;
          if (b != dofe_pkg::OPT_AGENT) begin
            res_vld = 1'b1;
            if (codes_r != 8'hFF) codes_nxt = codes_r + 8'd1;
          end
          phase_nxt = dofe_pkg::PH_LEN;
        end
      end
      dofe_pkg::PH_LEN: begin
        bytes_left_nxt = b;
        val_pos_nxt    = '0;
        if (cur_code_r == dofe_pkg::OPT_AGENT) begin
          sub_phase_nxt = dofe_pkg::SP_CODE;
          sub_code_nxt  = '0;
          sub_left_nxt  = '0;
          sub_pos_nxt   = '0;
          circ_ok_nxt   = 1'b0;
        end
        phase_nxt = (b == 8'd0) ? dofe_pkg::PH_CODE : dofe_pkg::PH_VALUE;
      end
      dofe_pkg::PH_VALUE: begin
        case (cur_code_r)
          dofe_pkg::OPT_MSG_TYPE: begin
            if (val_pos_r == 3'd0) type_nxt = b;
          end
          dofe_pkg::OPT_REQ_ADDR: begin
            case (val_pos_r)
              3'd0:    addr_nxt = {b, 24'd0};
              3'd1:    addr_nxt[23:16] = b;
              3'd2:    addr_nxt[15:8]  = b;
              3'd3:    addr_nxt[7:0]   = b;
              default: ;
            endcase
          end
          dofe_pkg::OPT_PARAM_LIST: begin
            res_vld  = 1'b1;
            res_kind = dofe_pkg::KIND_PARAM;
          end
          dofe_pkg::OPT_VENDOR: begin
            res_vld  = 1'b1;
            res_kind = dofe_pkg::KIND_VENDOR;
          end
          dofe_pkg::OPT_HOSTNAME: begin
            res_vld  = 1'b1;
            res_kind = dofe_pkg::KIND_HOSTNAME;
          end
          dofe_pkg::OPT_AGENT: begin
            case (sub_phase_r)
              dofe_pkg::SP_CODE: begin
                sub_code_nxt  = b;
                sub_phase_nxt = dofe_pkg::SP_LEN;
              end
              dofe_pkg::SP_LEN: begin
                sub_left_nxt  = b;
                sub_pos_nxt   = '0;
                circ_ok_nxt   = 1'b0;
                sub_phase_nxt = (b == 8'd0) ? dofe_pkg::SP_CODE : dofe_pkg::SP_VALUE;
              end
              default: begin
                if (sub_code_r == dofe_pkg::SUB_REMOTE && sub_pos_r >= 3'd2) begin
                  res_vld  = 1'b1;
                  res_kind = dofe_pkg::KIND_REMOTE;
                end else if (sub_code_r == dofe_pkg::SUB_CIRCUIT) begin
                  if (sub_pos_r == 3'd0) begin
                    circ_ok_nxt = (b == 8'd0);
                  end else if (sub_pos_r == 3'd1) begin
                    circ_ok_nxt = circ_ok_r && (b == dofe_pkg::CIRCUIT_LEN);
                  end else if (circ_ok_r) begin
                    case (sub_pos_r)
                      3'd2:    vlan_nxt[15:8] = b;
                      3'd3:    vlan_nxt[7:0]  = b;
                      3'd4:    unit_nxt       = b;
                      3'd5:    port_nxt       = b;
                      default: ;
                    endcase
                  end
                end
                if (sub_pos_r != 3'd7) sub_pos_nxt = sub_pos_r + 3'd1;
                sub_left_nxt = sub_left_r - 8'd1;
                if (sub_left_r == 8'd1) sub_phase_nxt = dofe_pkg::SP_CODE;
              end
            endcase
          end
          default: ;
        endcase
        if (val_pos_r != 3'd7) val_pos_nxt = val_pos_r + 3'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_r == 8'd1) phase_nxt = dofe_pkg::PH_CODE;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result assembly: data result first, summary after it on the last byte
  // --------------------------------------------------------------------------
  always_comb begin
    data_item            = '0;
    data_item.kind       = res_kind;
    data_item.value      = res_value;
    data_item.end_of_run = !in_data.last_byte;

    sum_item                   = '0;
    sum_item.kind              = dofe_pkg::KIND_SUMMARY;
    sum_item.message_type      = type_nxt;
    sum_item.requested_address = addr_nxt;
    sum_item.circuit_vlan      = vlan_nxt;
    sum_item.circuit_unit      = unit_nxt;
    sum_item.circuit_port      = port_nxt;
    sum_item.option_total      = codes_nxt;
    sum_item.reportable        = (type_nxt == dofe_pkg::MSG_DISCOVER) ||
                                 (type_nxt == dofe_pkg::MSG_REQUEST)  ||
                                 (type_nxt == dofe_pkg::MSG_INFORM);
    sum_item.end_of_run        = 1'b1;

    wr0    = res_vld ? data_item : sum_item;
    wr1    = sum_item;
    wr_cnt = in_acc ? ({1'b0, res_vld} + {1'b0, in_data.last_byte}) : 2'd0;
  end

  // --------------------------------------------------------------------------
  // Parser registers; the last byte returns everything to reset values
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_data.last_byte)) begin
      phase_r      <= dofe_pkg::PH_CODE;
      cur_code_r   <= '0;
      bytes_left_r <= '0;
      val_pos_r    <= '0;
      sub_phase_r  <= dofe_pkg::SP_CODE;
      sub_code_r   <= '0;
      sub_left_r   <= '0;
      sub_pos_r    <= '0;
      type_r       <= '0;
      addr_r       <= '0;
      vlan_r       <= '0;
      unit_r       <= '0;
      port_r       <= '0;
      circ_ok_r    <= 1'b0;
      codes_r      <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      cur_code_r   <= cur_code_nxt;
      bytes_left_r <= bytes_left_nxt;
      val_pos_r    <= val_pos_nxt;
      sub_phase_r  <= sub_phase_nxt;
      sub_code_r   <= sub_code_nxt;
      sub_left_r   <= sub_left_nxt;
      sub_pos_r    <= sub_pos_nxt;
      type_r       <= type_nxt;
      addr_r       <= addr_nxt;
      vlan_r       <= vlan_nxt;
      unit_r       <= unit_nxt;
      port_r       <= port_nxt;
      circ_ok_r    <= circ_ok_nxt;
      codes_r      <= codes_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two writes and one read per cycle
  // --------------------------------------------------------------------------
  dofe_pkg::out_item_t                q_r [dofe_pkg::QDEPTH];
  logic [dofe_pkg::QPTR_W-1:0]        wr_ptr_r, rd_ptr_r;
  logic [dofe_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                               rd_en;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign rd_en     = out_valid && !out_stall;
  // Need room for two results before taking a byte.
  assign in_stall  = (cnt_r > dofe_pkg::QCNT_W'(dofe_pkg::QDEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r + dofe_pkg::QCNT_W'(wr_cnt) - dofe_pkg::QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + dofe_pkg::QPTR_W'(wr_cnt);
      rd_ptr_r <= rd_ptr_r + dofe_pkg::QPTR_W'(rd_en);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) q_r[wr_ptr_r] <= wr0;
    if (wr_cnt == 2'd2) q_r[wr_ptr_r + dofe_pkg::QPTR_W'(1)] <= wr1;
  end

endmodule
